// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	localparam int COORD_W          = 32;
	localparam int IDX_W            = 6;
	localparam int CNT_W            = 7;
	localparam int DEF_MAX_VERTICES = 64;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// one word as it walks down the cell chain
	typedef struct packed {
		logic               is_query;
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] px;      // last active vertex seen so far
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] fx;      // vertex 0, for the closing edge
		logic [COORD_W-1:0] fy;
		logic               parity;
	} pip_word_t;

endpackage

`default_nettype wire

// ----- rtl/pip_edge_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        word_vld,
	input  pip_pkg::pip_word_t          word,
	input  logic [pip_pkg::COORD_W-1:0] ix,
	input  logic [pip_pkg::COORD_W-1:0] iy,
	input  logic [pip_pkg::COORD_W-1:0] jx,
	input  logic [pip_pkg::COORD_W-1:0] jy,
	input  logic                        en,
	output logic                        fwd_vld,
	output pip_pkg::pip_word_t          fwd_word
);
	import pip_pkg::*;

	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] dxq, dyj, dxe, dyq;
	logic                 strad;

	logic                 vld_s1;
	pip_word_t            w_s1;
	logic signed [DW-1:0] dxq_s1, dyj_s1, dxe_s1, dyq_s1;
	logic                 hit_s1;

	logic                 vld_s2;
	pip_word_t            w_s2;
	logic signed [PW-1:0] lp_s2, rp_s2;
	logic                 neg_s2;
	logic                 hit_s2;

	logic                 flip;
	pip_word_t            w_nxt;

	// exact differences, one bit wider than the coordinates
	assign dxq = {word.x[COORD_W-1], word.x} - {ix[COORD_W-1], ix};
	assign dyj = {jy[COORD_W-1], jy} - {iy[COORD_W-1], iy};
	assign dxe = {jx[COORD_W-1], jx} - {ix[COORD_W-1], ix};
	assign dyq = {word.y[COORD_W-1], word.y} - {iy[COORD_W-1], iy};

	assign strad = ($signed(iy) > $signed(word.y)) != ($signed(jy) > $signed(word.y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			fwd_vld <= 1'b0;
		end else begin
			vld_s1  <= word_vld;
			vld_s2  <= vld_s1;
			fwd_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		w_s1   <= word;
		dxq_s1 <= dxq;
		dyj_s1 <= dyj;
		dxe_s1 <= dxe;
		dyq_s1 <= dyq;
		hit_s1 <= strad && en && word.is_query;
	end

	// one multiplier per product, registered before the compare
	always_ff @(posedge clk) begin
		w_s2   <= w_s1;
		lp_s2  <= PW'(dxq_s1) * PW'(dyj_s1);
		rp_s2  <= PW'(dxe_s1) * PW'(dyq_s1);
		neg_s2 <= dyj_s1[DW-1];
		hit_s2 <= hit_s1;
	end

	// crossing right of the point: sign of dy flips the compare
	assign flip = hit_s2 && (neg_s2 ? (lp_s2 > rp_s2) : (lp_s2 < rp_s2));

	always_comb begin
		w_nxt        = w_s2;
		w_nxt.parity = w_s2.parity ^ flip;
	end

	always_ff @(posedge clk) begin
		fwd_word <= w_nxt;
	end

	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		word_vld |-> ##3 fwd_vld)
		else $error("word lost in edge unit");

	a_load_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !w_s1.is_query) |-> !hit_s1)
		else $error("load word marked as edge hit");

	a_hit_dy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && hit_s1) |-> (dyj_s1 != '0))
		else $error("straddling edge with zero dy");

endmodule

`default_nettype wire

// ----- rtl/pip_vertex_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pip_vertex_cell #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int CELL_IDX     = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pip_pkg::CNT_W-1:0] count,
	input  logic                      word_vld,
	input  pip_pkg::pip_word_t        word,
	output logic                      fwd_vld,
	output pip_pkg::pip_word_t        fwd_word
);
	import pip_pkg::*;

	localparam int CW = ($clog2(MAX_VERTICES + 1) > CNT_W) ?
		$clog2(MAX_VERTICES + 1) : CNT_W;
	localparam logic [CW-1:0] K_V = CW'(CELL_IDX);

	logic [COORD_W-1:0] vx_q, vy_q;
	logic               ld;
	logic               active;
	logic               en;
	pip_word_t          w_nxt;

	assign ld     = word_vld && (word.is_query == REQ_LOAD) && (CW'(word.idx) == K_V);
	assign active = CW'(count) > K_V;
	// cell 0 has no previous vertex; its edge is the closing one
	assign en     = active && (K_V != '0);

	always_ff @(posedge clk) begin
		if (ld) begin
			vx_q <= word.x;
			vy_q <= word.y;
		end
	end

	always_comb begin
		w_nxt = word;
		if (active) begin
			w_nxt.px = vx_q;
			w_nxt.py = vy_q;
		end
		if (active && (K_V == '0)) begin
			w_nxt.fx = vx_q;
			w_nxt.fy = vy_q;
		end
	end

	pip_edge_unit u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_vld (word_vld),
		.word     (w_nxt),
		.ix       (vx_q),
		.iy       (vy_q),
		.jx       (word.px),
		.jy       (word.py),
		.en       (en),
		.fwd_vld  (fwd_vld),
		.fwd_word (fwd_word)
	);

endmodule

`default_nettype wire

// ----- rtl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
`default_nettype none

// throughput: one word per clock, loads and queries alike, since every cell is fully pipelined
// busy never rises and results come out in input order; the receiver cannot stall
// reset clears vertex_count and every valid flag in the chain; vertex registers
// hold garbage until loaded and get no clearing pass

module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [pip_pkg::IDX_W-1:0]   vertex_index,
	input  logic [pip_pkg::COORD_W-1:0] coord_x,
	input  logic [pip_pkg::COORD_W-1:0] coord_y,
	// result side
	output logic                        done,
	output logic                        inside_res,
	// vertex_count write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pip_pkg::CNT_W-1:0]   cfg_data
);
	import pip_pkg::*;

	// accept edge to the edge at which done is sampled
	localparam int LAT = 3 * (MAX_VERTICES + 1) + 1;

	logic [CNT_W-1:0] count_q;
	logic             in_vld_q;
	pip_word_t        in_w_q;

	// chain taps: entry k feeds vertex cell k, entry MAX_VERTICES feeds the closing edge
	logic             chain_vld [MAX_VERTICES+1];
	pip_word_t        chain_w   [MAX_VERTICES+1];

	logic             close_vld;
	pip_word_t        close_w;

	// no state blocks intake; every cell hands its word on each clock
	assign busy      = 1'b0;
	// count must only change while the chain is empty; the block does not enforce this, cfg_ready is tied high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			in_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			in_vld_q <= start && !busy;
		end
	end

	// input word register; prev, first and parity start clear
	always_ff @(posedge clk) begin
		in_w_q.is_query <= (req_type == REQ_QUERY);
		in_w_q.idx      <= vertex_index;
		in_w_q.x        <= coord_x;
		in_w_q.y        <= coord_y;
		in_w_q.px       <= '0;
		in_w_q.py       <= '0;
		in_w_q.fx       <= '0;
		in_w_q.fy       <= '0;
		in_w_q.parity   <= 1'b0;
	end

	assign chain_vld[0] = in_vld_q;
	assign chain_w[0]   = in_w_q;

	// one cell per vertex slot; loads ride the chain so queries see them in order
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		pip_vertex_cell #(
			.MAX_VERTICES (MAX_VERTICES),
			.CELL_IDX     (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.word_vld (chain_vld[k]),
			.word     (chain_w[k]),
			.fwd_vld  (chain_vld[k+1]),
			.fwd_word (chain_w[k+1])
		);
	end

	// closing edge from the last active vertex back to vertex 0
	pip_edge_unit u_close (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_vld (chain_vld[MAX_VERTICES]),
		.word     (chain_w[MAX_VERTICES]),
		.ix       (chain_w[MAX_VERTICES].fx),
		.iy       (chain_w[MAX_VERTICES].fy),
		.jx       (chain_w[MAX_VERTICES].px),
		.jy       (chain_w[MAX_VERTICES].py),
		.en       (count_q != '0),
		.fwd_vld  (close_vld),
		.fwd_word (close_w)
	);

	// loads leave the chain silently; a query gives its parity
	assign done       = close_vld && close_w.is_query;
	assign inside_res = close_w.parity;

	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching accepted word");

	a_done_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(req_type, LAT) == REQ_QUERY))
		else $error("result produced for a vertex load");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(close_vld && !close_w.is_query) |-> !done)
		else $error("load word raised done");

endmodule

`default_nettype wire
